@@ design/itdds_pkg.sv @@
// Shared types and constants for the integer to decimal digit stream block.
package itdds_pkg;

    // Field widths and conversion sizes
    localparam int NUM_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);

    // Largest value that passes through unconverted
    localparam int MAX_PASS   = 9;

    // Input request payload
    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic                    end_of_array;
    } item_t;

    // Output request payload
    typedef struct packed {
        logic signed [NUM_W-1:0] digit_value;
        logic                    last_of_number;
        logic                    last_of_array;
    } digit_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

@@ design/integer_to_decimal_digit_stream.sv @@
// Top level: bit-serial binary to decimal digit stream converter.
//
//   channel | direction | handshake                | payload
//   item    | in        | item_valid / item_ready  | item  (number, end_of_array)
//   digit   | out       | digit_valid / digit_ready| digit (digit_value, last flags)
//
// A value of nine or less (negatives included) passes through as one request out.
// A larger value goes through the sequencer states in order: the shift-and-add-3 loop
// runs one input bit per cycle, leading zero digits are dropped one per cycle until the
// first nonzero digit is found, digits are sent one per cycle while the output is not
// stalled, and the idle state takes the next request.
// Reset clears the sequencer and the output valid; nothing else needs clearing.
// A stalled output holds the current digit and the sequencer waits on it.
module integer_to_decimal_digit_stream (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  itdds_pkg::item_t item,
    output logic             digit_valid,
    input  logic             digit_ready,
    output itdds_pkg::digit_t digit
);
    import itdds_pkg::*;

    state_t              state_reg, state_next;
    logic [NUM_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                eoa_reg, eoa_next;
    logic                out_valid_reg, out_valid_next;
    digit_t              out_reg, out_next;
    logic                out_free;
    logic                accept;
    logic                above_nine;
    logic                last_digit;
    logic [DIGIT_W-1:0]  top_digit;

    // Output register can take a new request this cycle
    assign out_free   = !out_valid_reg || digit_ready;
    assign item_ready = (state_reg == ST_IDLE) && out_free;
    assign accept     = item_valid && item_ready;

    assign above_nine = !item.number[NUM_W-1]
                        && (item.number[NUM_W-2:0] > (NUM_W-1)'(MAX_PASS));
    assign top_digit  = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign last_digit = (left_reg == LEFT_W'(1));

    // Add 3 to every BCD digit of 5 or more ahead of the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        eoa_next       = eoa_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !digit_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eoa_next = item.end_of_array;
                    if (above_nine)
                    begin
                        bin_next   = item.number;
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        // Pass small and negative values through unchanged
                        out_next.digit_value    = item.number;
                        out_next.last_of_number = 1'b1;
                        out_next.last_of_array  = item.end_of_array;
                        out_valid_next          = 1'b1;
                    end
                end
            end

            ST_CONV:
            begin
                // Shift one binary bit into the BCD register
                {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    left_next  = LEFT_W'(BCD_DIGITS);
                    state_next = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // Drop leading zero digits; the value is above nine, so this ends
                if (top_digit == '0)
                begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Send the top digit whenever the output register is free
                if (out_free)
                begin
                    out_next.digit_value    = $signed({{(NUM_W-DIGIT_W){1'b0}}, top_digit});
                    out_next.last_of_number = last_digit;
                    out_next.last_of_array  = last_digit && eoa_reg;
                    out_valid_next          = 1'b1;
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                    if (last_digit)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        left_reg <= left_next;
        eoa_reg  <= eoa_next;
        out_reg  <= out_next;
    end

    assign digit_valid = out_valid_reg;
    assign digit       = out_reg;

endmodule

@@ design/itdds_checker.sv @@
// Port-level checker for the digit stream converter, bound to the top level.
module itdds_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input itdds_pkg::item_t  item,
    input logic              digit_valid,
    input logic              digit_ready,
    input itdds_pkg::digit_t digit
);
    import itdds_pkg::*;

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_ready |=> digit_valid && $stable(digit))
        else $error("output request changed while stalled");

    // End of array only on the final digit of a number
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit.last_of_array |-> digit.last_of_number)
        else $error("last_of_array without last_of_number");

    // Digits before the last one of a number are decimal digits
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit.last_of_number
        |-> $signed(digit.digit_value) >= 0 && $signed(digit.digit_value) <= MAX_PASS)
        else $error("non-final digit out of range");

    // A converted value blocks input and output right after it is taken
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && $signed(item.number) > MAX_PASS
        |=> !digit_valid && !item_ready)
        else $error("converter not busy after taking a large value");

endmodule

bind integer_to_decimal_digit_stream itdds_checker u_itdds_checker (.*);

@@ sim/integer_to_decimal_digit_stream_tb.sv @@
// Testbench for integer_to_decimal_digit_stream: directed table, random stream, digit checks.
module integer_to_decimal_digit_stream_tb;

    import itdds_pkg::*;

    localparam int RADIX       = 10;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_ROWS    = 20;

    // How a directed row gets its expected digits
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_PASS,
        ROW_DIGITS
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic signed [NUM_W-1:0] number;
        logic                    end_of_array;
        logic [3:0]              n_digits;
        logic [BCD_W-1:0]        bcd;
    } dir_row_t;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   item_valid   = 1'b0;
    logic   item_ready;
    item_t  item         = '0;
    logic   digit_valid;
    logic   digit_ready  = 1'b0;
    digit_t digit;

    digit_t expected_digits [$];
    int     error_count   = 0;
    int     cycle_count   = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    // Typed rows use BCD, least significant digit in the low nibble
    dir_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_PASS,    32'sd0,          1'b0, 4'd0,  40'h0},
        '{ROW_PASS,    32'sd9,          1'b1, 4'd0,  40'h0},
        '{ROW_DIGITS,  32'sd10,         1'b0, 4'd2,  40'h10},
        '{ROW_PASS,    -32'sd1,         1'b0, 4'd0,  40'h0},
        '{ROW_PASS,    32'sh80000000,   1'b1, 4'd0,  40'h0},
        '{ROW_DIGITS,  32'sd2147483647, 1'b1, 4'd10, 40'h2147483647},
        '{ROW_PASS,    32'sd1,          1'b0, 4'd0,  40'h0},
        '{ROW_PASS,    -32'sd9,         1'b0, 4'd0,  40'h0},
        '{ROW_PASS,    -32'sd10,        1'b1, 4'd0,  40'h0},
        '{ROW_PASS,    32'shAAAAAAAA,   1'b0, 4'd0,  40'h0},
        '{ROW_DIGITS,  32'sd123456789,  1'b1, 4'd9,  40'h0123456789},
        '{ROW_PREDICT, 32'sd11,         1'b1, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd99,         1'b0, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd100,        1'b0, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd999999999,  1'b0, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd1000000000, 1'b1, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sh55555555,   1'b0, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sh2AAAAAAA,   1'b0, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd2000000000, 1'b1, 4'd0,  40'h0},
        '{ROW_PREDICT, 32'sd1000000007, 1'b0, 4'd0,  40'h0}
    };

    integer_to_decimal_digit_stream uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit)
    );

    always #10 clk = ~clk;

    // Queue one expected digit request
    task automatic push_digit(input logic signed [NUM_W-1:0] value, input logic last_num,
                              input logic last_arr);
        digit_t d;
        d.digit_value    = value;
        d.last_of_number = last_num;
        d.last_of_array  = last_arr;
        expected_digits.push_back(d);
    endtask

    // Split a number above nine into decimal digits, most significant first; queue smaller ones whole
    task automatic predict_digits(input item_t it);
        logic [NUM_W-1:0] mag;
        logic [3:0]       dig [BCD_DIGITS];
        int               n;
        n = 0;
        if (it.number <= MAX_PASS)
        begin
            push_digit(it.number, 1'b1, it.end_of_array);
        end
        else
        begin
            mag = it.number;
            while (mag != 0)
            begin
                dig[n] = 4'(mag % RADIX);
                mag    = mag / RADIX;
                n++;
            end
            for (int k = n - 1; k >= 0; k--)
                push_digit({28'd0, dig[k]}, k == 0, (k == 0) && it.end_of_array);
        end
    endtask

    // Offer one request, idling first at the current rate; return once accepted
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Drop the request and hold off the sender until every expected digit has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    // Random number: small, bounded digit count, near a power of ten, or full range
    function automatic logic signed [NUM_W-1:0] random_number();
        logic [63:0] acc;
        int          sel;
        int          n;
        acc = '0;
        sel = $urandom_range(9);
        if (sel < 3)
            return $signed($urandom_range(40)) - 20;
        if (sel < 6)
        begin
            n = $urandom_range(1, BCD_DIGITS);
            repeat (n)
                acc = acc * RADIX + $urandom_range(9);
            if (acc > 64'h7FFFFFFF)
                acc = acc & 64'h7FFFFFFF;
            return acc[NUM_W-1:0];
        end
        if (sel == 6)
        begin
            acc = 64'd1;
            repeat ($urandom_range(1, 9))
                acc = acc * RADIX;
            acc = acc + $urandom_range(2) - 1;
            return acc[NUM_W-1:0];
        end
        return $urandom;
    endfunction

    task automatic run_phase(input int send_pct, input int recv_pct);
        item_t it;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_ITEMS)
        begin
            it.number       = random_number();
            it.end_of_array = ($urandom_range(7) == 0);
            send_item(it);
            predict_digits(it);
        end
    endtask

    // Receiver stalls at the current rate
    always @(posedge clk)
        digit_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted digit with the oldest expectation
    always @(posedge clk)
    begin : check_digits
        digit_t want;
        if (rst_n && digit_valid && digit_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit request: digit_value %0d", digit.digit_value);
                error_count++;
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit.digit_value !== want.digit_value)
                begin
                    $error("digit_value: expected %0d, got %0d",
                           want.digit_value, digit.digit_value);
                    error_count++;
                end
                if (digit.last_of_number !== want.last_of_number)
                begin
                    $error("last_of_number: expected %0b, got %0b",
                           want.last_of_number, digit.last_of_number);
                    error_count++;
                end
                if (digit.last_of_array !== want.last_of_array)
                begin
                    $error("last_of_array: expected %0b, got %0b",
                           want.last_of_array, digit.last_of_array);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("integer_to_decimal_digit_stream_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        item_t    it;
        dir_row_t row;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        send_idle_pct = 38;
        recv_idle_pct = 74;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row             = directed_rows[r];
            it.number       = row.number;
            it.end_of_array = row.end_of_array;
            send_item(it);
            case (row.kind)
                ROW_PASS:
                    push_digit(row.number, 1'b1, row.end_of_array);
                ROW_DIGITS:
                    for (int k = row.n_digits - 1; k >= 0; k--)
                        push_digit({28'd0, row.bcd[k*DIGIT_W +: DIGIT_W]}, k == 0,
                                   (k == 0) && row.end_of_array);
                default:
                    predict_digits(it);
            endcase
        end

        // Random stream in three idling phases, draining between them
        wait_drained();
        run_phase(38, 74);
        wait_drained();
        run_phase(74, 38);
        wait_drained();
        run_phase(0, 0);

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (error_count == 0)
            $display("integer_to_decimal_digit_stream_tb OK");
        else
            $display("integer_to_decimal_digit_stream_tb NOT OK");
        $finish;
    end

endmodule
